// ===== rtl/irl_pkg.sv =====
// Shared definitions for the index range lookup block.
// Holds item codes, status codes, state types and the scan result struct.
// No dependencies.
package irl_pkg;

    // Item codes carried on the action field
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Fixed payload widths
    localparam int OFF_W = 32;
    localparam int SUM_W = 33;

    // Scan sequencer states
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_FWD,
        SCAN_BWD,
        SCAN_DONE
    } scan_state_t;

    // Scan outcome handed back to the top level
    typedef struct packed {
        logic             done;
        logic             start_found;
        logic             end_found;
        logic [OFF_W-1:0] start_off;
        logic [SUM_W-1:0] end_off;
    } scan_res_t;

endpackage

// ===== rtl/irl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the entry table of the index range lookup block.
// No dependencies.
module irl_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/irl_scan.sv =====
// Scan sequencer: forward then backward walk over the entry table.
// One shared subtract-compare unit serves both walks, one RAM read per cycle.
// Depends on irl_pkg.
module irl_scan
    import irl_pkg::*;
#(
    parameter int KEY_WIDTH   = 64,
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
    input  logic [KEY_WIDTH-1:0]               lo_key,
    input  logic [KEY_WIDTH-1:0]               hi_key,
    output logic                               rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
    input  logic [KEY_WIDTH+2*OFF_W-1:0]       rd_data,
    output scan_res_t                          res,
    output logic                               busy
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);

    scan_state_t            state_reg, state_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic                   last_reg, last_next;
    logic [KEY_WIDTH-1:0]   lo_reg, lo_next;
    logic [KEY_WIDTH-1:0]   hi_reg, hi_next;
    logic                   sfound_reg, sfound_next;
    logic                   efound_reg, efound_next;
    logic [OFF_W-1:0]       soff_reg, soff_next;
    logic [SUM_W-1:0]       eoff_reg, eoff_next;

    logic [KEY_WIDTH-1:0]   rd_key;
    logic [OFF_W-1:0]       rd_off;
    logic [OFF_W-1:0]       rd_len;
    logic [KEY_WIDTH-1:0]   cmp_a;
    logic [KEY_WIDTH-1:0]   cmp_b;
    logic [KEY_WIDTH:0]     cmp_diff;
    logic                   match;

    // Split the stored word into key, offset and length
    assign rd_key = rd_data[KEY_WIDTH+2*OFF_W-1:2*OFF_W];
    assign rd_off = rd_data[2*OFF_W-1:OFF_W];
    assign rd_len = rd_data[OFF_W-1:0];

    // Shared compare: a >= b when the subtraction does not borrow
    assign cmp_a    = (state_reg == SCAN_FWD) ? rd_key : hi_reg;
    assign cmp_b    = (state_reg == SCAN_FWD) ? lo_reg : rd_key;
    assign cmp_diff = {1'b0, cmp_a} - {1'b0, cmp_b};
    assign match    = ~cmp_diff[KEY_WIDTH];

    // State and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SCAN_IDLE;
            pend_reg   <= 1'b0;
            last_reg   <= 1'b0;
            sfound_reg <= 1'b0;
            efound_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            last_reg   <= last_next;
            sfound_reg <= sfound_next;
            efound_reg <= efound_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        soff_reg <= soff_next;
        eoff_reg <= eoff_next;
    end

    // Sequencer: issue one read per cycle and check its data in the next cycle
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        last_next       = last_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        sfound_next     = sfound_reg;
        efound_next     = efound_reg;
        soff_next       = soff_reg;
        eoff_next       = eoff_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[AW-1:0];
        res.done        = 1'b0;
        res.start_found = sfound_reg;
        res.end_found   = efound_reg;
        res.start_off   = soff_reg;
        res.end_off     = eoff_reg;

        case (state_reg)
            SCAN_IDLE:
            begin
                // Latch the query and start at the oldest entry
                if (go)
                begin
                    lo_next     = lo_key;
                    hi_next     = hi_key;
                    cnt_next    = count;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    last_next   = 1'b0;
                    sfound_next = 1'b0;
                    efound_next = 1'b0;
                    soff_next   = '0;
                    eoff_next   = '0;
                    state_next  = SCAN_FWD;
                end
            end
            SCAN_FWD:
            begin
                if (pend_reg && match)
                begin
                    // First key at or above the start key
                    sfound_next = 1'b1;
                    soff_next   = rd_off;
                    idx_next    = cnt_reg - CW'(1);
                    pend_next   = 1'b0;
                    state_next  = SCAN_BWD;
                end
                else if (pend_reg && last_reg)
                begin
                    idx_next   = cnt_reg - CW'(1);
                    pend_next  = 1'b0;
                    state_next = SCAN_BWD;
                end
                else
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    last_next = (idx_reg == cnt_reg - CW'(1));
                    idx_next  = idx_reg + CW'(1);
                end
            end
            SCAN_BWD:
            begin
                if (pend_reg && match)
                begin
                    // Last key at or below the end key
                    efound_next = 1'b1;
                    eoff_next   = {1'b0, rd_off} + {1'b0, rd_len};
                    pend_next   = 1'b0;
                    state_next  = SCAN_DONE;
                end
                else if (pend_reg && last_reg)
                begin
                    pend_next  = 1'b0;
                    state_next = SCAN_DONE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    last_next = (idx_reg == '0);
                    idx_next  = idx_reg - CW'(1);
                end
            end
            SCAN_DONE:
            begin
                res.done   = 1'b1;
                state_next = SCAN_IDLE;
            end
            default:
            begin
                state_next = SCAN_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != SCAN_IDLE);

`ifndef SYNTHESIS
    // Reads stay inside the filled part of the table
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (idx_reg < cnt_reg))
        else $error("scan read beyond entry count");

    // A scan starts only from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        go |-> (state_reg == SCAN_IDLE))
        else $error("scan started while busy");

    // The start hit is taken only by the forward walk
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sfound_reg) |-> ($past(state_reg) == SCAN_FWD))
        else $error("start hit outside forward walk");
`endif

endmodule

// ===== rtl/index_range_lookup.sv =====
// Index range lookup: entry table with clear, append and range query words.
// Non-query words and empty-table queries: result in the cycle after acceptance.
// A query on a filled table returns its result once the forward and backward
// walks finish; one RAM read port and one comparer walk the table.
// A new word is taken while the output word drains.
// Reset (rst_n low, async) empties the table; entries are not cleared.
module index_range_lookup
    import irl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [63:0]       entry_key,
    input  logic [31:0]       entry_offset,
    input  logic [31:0]       entry_length,
    input  logic [63:0]       query_start_key,
    input  logic [63:0]       query_end_key,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [31:0]       start_offset,
    output logic [32:0]       end_offset,
    output logic              start_found,
    output logic              end_found
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int DW = KEY_WIDTH + 2 * OFF_W;

    logic [CW-1:0]    count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [OFF_W-1:0] soff_reg, soff_next;
    logic [SUM_W-1:0] eoff_reg, eoff_next;
    logic             sf_reg, sf_next;
    logic             ef_reg, ef_next;

    logic             accept;
    logic             out_fire;
    logic             go;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [DW-1:0]    rd_data;
    logic             scan_busy;
    scan_res_t        res;

    // Hold input while scanning or while the output word is stuck
    assign accept   = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = scan_busy || (out_valid_reg && out_stall);

    // Entry table
    irl_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({entry_key[KEY_WIDTH-1:0], entry_offset, entry_length}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Forward and backward scan
    irl_scan #(
        .KEY_WIDTH   (KEY_WIDTH),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .count   (count_reg),
        .lo_key  (query_start_key[KEY_WIDTH-1:0]),
        .hi_key  (query_end_key[KEY_WIDTH-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (res),
        .busy    (scan_busy)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        soff_reg   <= soff_next;
        eoff_reg   <= eoff_next;
        sf_reg     <= sf_next;
        ef_reg     <= ef_next;
    end

    // Decode the accepted word, update the count and load the output word
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        soff_next      = soff_reg;
        eoff_next      = eoff_reg;
        sf_next        = sf_reg;
        ef_next        = ef_reg;
        go             = 1'b0;
        wr_en          = 1'b0;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = STATUS_OK;
            soff_next      = '0;
            eoff_next      = '0;
            sf_next        = 1'b0;
            ef_next        = 1'b0;
            case (action)
                ACT_CLEAR:
                begin
                    count_next = '0;
                end
                ACT_APPEND:
                begin
                    if (count_reg == CW'(TABLE_DEPTH))
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_QUERY:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        // Result comes back from the scan
                        go             = 1'b1;
                        out_valid_next = 1'b0;
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end

        if (res.done)
        begin
            out_valid_next = 1'b1;
            status_next    = STATUS_OK;
            soff_next      = res.start_off;
            eoff_next      = res.end_off;
            sf_next        = res.start_found;
            ef_next        = res.end_found;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign start_offset = soff_reg;
    assign end_offset   = eoff_reg;
    assign start_found  = sf_reg;
    assign end_found    = ef_reg;

`ifndef SYNTHESIS
    // No input word is taken while a scan runs
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_busy |-> in_stall)
        else $error("input taken during scan");

    // Entry count never exceeds the table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count overflow");

    // The output slot is free when a scan finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> !out_valid_reg)
        else $error("scan result would overwrite pending word");
`endif

endmodule

// ===== test/index_range_lookup_checker.sv =====
`timescale 1ns / 100ps
// Checker for the index range lookup block: watches both channels, keeps its
// own copy of the entry table and compares each result word with a prediction.
// Depends on irl_pkg for the action and status codes.
module index_range_lookup_checker
    import irl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic [63:0] entry_key,
    input  logic [31:0] entry_offset,
    input  logic [31:0] entry_length,
    input  logic [63:0] query_start_key,
    input  logic [63:0] query_end_key,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [31:0] start_offset,
    input  logic [32:0] end_offset,
    input  logic        start_found,
    input  logic        end_found,
    output int          fail_count,
    output int          pending_count
);

    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_WIDTH);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] start_off;
        logic [32:0] end_off;
        logic        start_found;
        logic        end_found;
    } lookup_result_t;

    // Shadow copy of the entry table
    logic [63:0] stored_keys    [TABLE_DEPTH];
    logic [31:0] stored_offsets [TABLE_DEPTH];
    logic [31:0] stored_lengths [TABLE_DEPTH];
    int          stored_count = 0;

    lookup_result_t pending_results [$];
    int             error_total = 0;

    // Apply one input word to the shadow table and return the result it causes
    function automatic lookup_result_t lookup_word(
        input logic [1:0]  act,
        input logic [63:0] key,
        input logic [31:0] off,
        input logic [31:0] len,
        input logic [63:0] lo_key,
        input logic [63:0] hi_key
    );
        lookup_result_t res;
        logic [63:0]    lo;
        logic [63:0]    hi;
        int             i;
        res        = '0;
        res.status = STATUS_OK;
        lo         = lo_key & KEY_MASK;
        hi         = hi_key & KEY_MASK;
        case (act)
            ACT_CLEAR:
            begin
                stored_count = 0;
            end
            ACT_APPEND:
            begin
                if (stored_count >= TABLE_DEPTH)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    stored_keys[stored_count]    = key & KEY_MASK;
                    stored_offsets[stored_count] = off;
                    stored_lengths[stored_count] = len;
                    stored_count++;
                end
            end
            ACT_QUERY:
            begin
                if (stored_count == 0)
                begin
                    res.status = STATUS_EMPTY;
                end
                else
                begin
                    // Forward scan: first key at or above the start key
                    for (i = 0; i < stored_count; i++)
                    begin
                        if (stored_keys[i] >= lo)
                        begin
                            res.start_off   = stored_offsets[i];
                            res.start_found = 1'b1;
                            break;
                        end
                    end
                    // Backward scan: last key at or below the end key
                    for (i = stored_count - 1; i >= 0; i--)
                    begin
                        if (stored_keys[i] <= hi)
                        begin
                            res.end_off   = {1'b0, stored_offsets[i]} +
                                            {1'b0, stored_lengths[i]};
                            res.end_found = 1'b1;
                            break;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Check result words first, then queue predictions for new input words
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    if (error_total < 10)
                        $display("%t: result word with nothing expected: status %0d", $realtime,
                                 status);
                    error_total++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if ((status !== want.status) ||
                        (start_offset !== want.start_off) ||
                        (end_offset !== want.end_off) ||
                        (start_found !== want.start_found) ||
                        (end_found !== want.end_found))
                    begin
                        if (error_total < 10)
                            $display({"%t: mismatch: status %0d/%0d start_off %h/%h ",
                                      "end_off %h/%h start_found %b/%b end_found %b/%b ",
                                      "(expected/actual)"}, $realtime,
                                     want.status, status, want.start_off, start_offset,
                                     want.end_off, end_offset,
                                     want.start_found, start_found,
                                     want.end_found, end_found);
                        error_total++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_results = {pending_results,
                                   lookup_word(action, entry_key, entry_offset,
                                               entry_length, query_start_key,
                                               query_end_key)};
        end
        pending_count <= pending_results.size();
        fail_count    <= error_total + pending_results.size();
    end

endmodule

// ===== test/index_range_lookup_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the index range lookup block: drives clear, append,
// query and unused words under several idle/stall mixes and gives the verdict.
// Depends on irl_pkg, the block and index_range_lookup_checker.
module index_range_lookup_tb;
    import irl_pkg::*;

    localparam int          TABLE_DEPTH = 1024;
    localparam int          KEY_WIDTH   = 64;
    localparam int          IDLE_LIMIT  = 20000;
    localparam int          LONG_FILL   = 40;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam logic [63:0] KEY_TOP     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] WORD_TOP    = 32'hFFFF_FFFF;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_stall;
    logic [1:0]  action          = ACT_CLEAR;
    logic [63:0] entry_key       = '0;
    logic [31:0] entry_offset    = '0;
    logic [31:0] entry_length    = '0;
    logic [63:0] query_start_key = '0;
    logic [63:0] query_end_key   = '0;
    logic        out_valid;
    logic        out_stall       = 1'b0;
    logic [1:0]  status;
    logic [31:0] start_offset;
    logic [32:0] end_offset;
    logic        start_found;
    logic        end_found;

    int fail_count;
    int pending_count;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles;
    int phase;

    always #6 clk = ~clk;

    index_range_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .entry_key       (entry_key),
        .entry_offset    (entry_offset),
        .entry_length    (entry_length),
        .query_start_key (query_start_key),
        .query_end_key   (query_end_key),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .start_offset    (start_offset),
        .end_offset      (end_offset),
        .start_found     (start_found),
        .end_found       (end_found)
    );

    index_range_lookup_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .entry_key       (entry_key),
        .entry_offset    (entry_offset),
        .entry_length    (entry_length),
        .query_start_key (query_start_key),
        .query_end_key   (query_end_key),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .start_offset    (start_offset),
        .end_offset      (end_offset),
        .start_found     (start_found),
        .end_found       (end_found),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    // Stall the result channel at the current rate
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Mostly small keys so scans hit, some near the top, some anywhere
    function automatic logic [63:0] rand_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 64'($urandom_range(0, 40));
        else if (pick < 8)
            return KEY_TOP - 64'($urandom_range(0, 40));
        else
            return {$urandom, $urandom};
    endfunction

    // Offsets and lengths: mostly anywhere, with zero, top and small values
    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return $urandom;
        else if (pick == 7)
            return '0;
        else if (pick == 8)
            return WORD_TOP;
        else
            return 32'($urandom_range(0, 255));
    endfunction

    // Present one input word after random idle cycles and hold it until taken
    task automatic send_word(
        input logic [1:0]  act,
        input logic [63:0] key,
        input logic [31:0] off,
        input logic [31:0] len,
        input logic [63:0] lo_key,
        input logic [63:0] hi_key
    );
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        action          <= act;
        entry_key       <= key;
        entry_offset    <= off;
        entry_length    <= len;
        query_start_key <= lo_key;
        query_end_key   <= hi_key;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random(input logic [1:0] act);
        send_word(act, rand_key(), rand_word(), rand_word(), rand_key(), rand_key());
    endtask

    // Hold off the sender until every expected result word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Random words: mostly clear/append/query runs, the rest noise
    task automatic run_random(input int count);
        int sent;
        int n_app;
        int n_qry;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    send_random(ACT_CLEAR);
                    sent++;
                end
                n_app = $urandom_range(1, 12);
                n_qry = $urandom_range(1, 4);
                repeat (n_app) send_random(ACT_APPEND);
                repeat (n_qry) send_random(ACT_QUERY);
                sent += n_app + n_qry;
            end
            else
            begin
                send_random(2'($urandom_range(0, 3)));
                sent++;
            end
        end
    endtask

    // Build a longer table, then scan it end to end with extreme bounds
    task automatic run_long_table();
        int k;
        send_random(ACT_CLEAR);
        for (k = 0; k < LONG_FILL; k++)
            send_random(ACT_APPEND);
        send_word(ACT_QUERY, rand_key(), rand_word(), rand_word(), '0, KEY_TOP);
        send_random(ACT_QUERY);
        send_word(ACT_QUERY, rand_key(), rand_word(), rand_word(), KEY_TOP, '0);
        send_random(ACT_UNUSED);
        send_random(ACT_CLEAR);
        send_random(ACT_QUERY);
    endtask

    // End the run when nothing moves on either channel for too long
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: empty table, extremes, found and not found
        send_word(ACT_QUERY, '0, '0, '0, '0, KEY_TOP);
        send_word(ACT_UNUSED, KEY_TOP, WORD_TOP, WORD_TOP, KEY_TOP, KEY_TOP);
        send_word(ACT_CLEAR, '0, '0, '0, '0, '0);
        send_word(ACT_APPEND, '0, '0, '0, '0, '0);
        send_word(ACT_APPEND, KEY_TOP, WORD_TOP, WORD_TOP, '0, '0);
        send_word(ACT_APPEND, 64'd5, 32'd123, 32'd77, '0, '0);
        send_word(ACT_QUERY, '0, '0, '0, '0, KEY_TOP);
        send_word(ACT_QUERY, '0, '0, '0, KEY_TOP, '0);
        send_word(ACT_QUERY, '0, '0, '0, KEY_TOP, KEY_TOP);
        send_word(ACT_QUERY, '0, '0, '0, 64'd6, 64'd4);
        send_word(ACT_CLEAR, '0, '0, '0, '0, '0);
        send_word(ACT_APPEND, 64'd100, 32'hDEAD_BEEF, 32'h1000, '0, '0);
        send_word(ACT_QUERY, '0, '0, '0, 64'd200, 64'd50);
        send_word(ACT_QUERY, '0, '0, '0, 64'd100, 64'd100);
        send_word(ACT_UNUSED, KEY_TOP, WORD_TOP, WORD_TOP, '0, '0);
        send_word(ACT_QUERY, '0, '0, '0, '0, KEY_TOP);
        send_word(ACT_CLEAR, '0, '0, '0, '0, '0);
        send_word(ACT_QUERY, '0, '0, '0, '0, KEY_TOP);
        wait_drained();

        // Random words under each idle/stall mix, draining between mixes
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 63; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            run_random(50);
            wait_drained();
        end

        idle_pct  = 0;
        stall_pct = 37;
        run_long_table();

        // Let the last words drain, then give the verdict
        wait_drained();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
